FILE: design/qpt_pkg.sv
// ----------------------------------------------------------------------------
// qpt_pkg: shared types and constants for the quaternion point transform
// Widths of the fixed-point datapath, register indexes and stage controls.
// ----------------------------------------------------------------------------
package qpt_pkg;

   localparam int COORD_W = 32;               // Q16.16 coordinates and offsets
   localparam int QUAT_W  = 32;               // Q2.30 quaternion components
   localparam int QP_W    = 34;               // rounded Q.30 quaternion product
   localparam int MAT_W   = 36;               // rotation matrix entry, Q.30
   localparam int PROD_W  = MAT_W + 17;       // entry times one 16-bit half
   localparam int HI_W    = PROD_W + 2;       // sum of three high-half products
   localparam int LO_W    = 64;               // low-half sum plus shifted offset
   localparam int TOT_W   = HI_W + 17;        // full Q.46 row sum
   localparam int FRAC_Q  = 30;               // fraction bits of Q.30
   localparam int RND_W   = TOT_W - FRAC_Q;   // row sum rounded to Q16.16
   localparam int IDX_W   = 3;

   typedef enum logic [IDX_W-1:0] {
      REG_ROT_W    = 3'd0,
      REG_ROT_X    = 3'd1,
      REG_ROT_Y    = 3'd2,
      REG_ROT_Z    = 3'd3,
      REG_OFFSET_X = 3'd4,
      REG_OFFSET_Y = 3'd5,
      REG_OFFSET_Z = 3'd6
   } cfg_reg_type;

   // Per-stage load enables of the row pipeline
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_adv_type;

endpackage

FILE: design/qpt_coef.sv
// ----------------------------------------------------------------------------
// qpt_coef: configuration registers and rotation matrix
// Holds the quaternion and offset, forms the matrix over two register stages
// and flags busy until the matrix matches the latest write.
// ----------------------------------------------------------------------------
module qpt_coef
   import qpt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [IDX_W-1:0]         csr_index,
   input  logic [COORD_W-1:0]       csr_wdata,
   output logic signed [MAT_W-1:0]  mat_ff [3][3],
   output logic signed [COORD_W-1:0] offset_ff [3],
   output logic                     busy
);

   localparam logic [1:0] SETTLE = 2'd2;

   logic signed [QUAT_W-1:0] quat_ff [4];      // w, x, y, z
   logic signed [2*QUAT_W-1:0] prod_ff [9];    // xx yy zz xy xz yz wx wy wz
   logic signed [QP_W-1:0]   qp [9];
   logic signed [MAT_W-1:0]  mat_in [3][3];
   logic signed [MAT_W-1:0]  one_q30;
   logic [1:0]               settle_ff;

   function automatic logic signed [QP_W-1:0] round_q30(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + 64'sd536870912;
      return t[63:FRAC_Q];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_ff[0]   <= 32'sd1073741824;
         quat_ff[1]   <= '0;
         quat_ff[2]   <= '0;
         quat_ff[3]   <= '0;
         offset_ff[0] <= '0;
         offset_ff[1] <= '0;
         offset_ff[2] <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ROT_W:    quat_ff[0]   <= csr_wdata;
            REG_ROT_X:    quat_ff[1]   <= csr_wdata;
            REG_ROT_Y:    quat_ff[2]   <= csr_wdata;
            REG_ROT_Z:    quat_ff[3]   <= csr_wdata;
            REG_OFFSET_X: offset_ff[0] <= csr_wdata;
            REG_OFFSET_Y: offset_ff[1] <= csr_wdata;
            REG_OFFSET_Z: offset_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Hold off points until the new products and matrix have settled
   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         settle_ff <= SETTLE;
      end else if (settle_ff != 2'd0) begin
         settle_ff <= settle_ff - 2'd1;
      end
   end

   assign busy = (settle_ff != 2'd0);

   always_ff @(posedge clock) begin
      prod_ff[0] <= (2*QUAT_W)'(quat_ff[1]) * (2*QUAT_W)'(quat_ff[1]);
      prod_ff[1] <= (2*QUAT_W)'(quat_ff[2]) * (2*QUAT_W)'(quat_ff[2]);
      prod_ff[2] <= (2*QUAT_W)'(quat_ff[3]) * (2*QUAT_W)'(quat_ff[3]);
      prod_ff[3] <= (2*QUAT_W)'(quat_ff[1]) * (2*QUAT_W)'(quat_ff[2]);
      prod_ff[4] <= (2*QUAT_W)'(quat_ff[1]) * (2*QUAT_W)'(quat_ff[3]);
      prod_ff[5] <= (2*QUAT_W)'(quat_ff[2]) * (2*QUAT_W)'(quat_ff[3]);
      prod_ff[6] <= (2*QUAT_W)'(quat_ff[0]) * (2*QUAT_W)'(quat_ff[1]);
      prod_ff[7] <= (2*QUAT_W)'(quat_ff[0]) * (2*QUAT_W)'(quat_ff[2]);
      prod_ff[8] <= (2*QUAT_W)'(quat_ff[0]) * (2*QUAT_W)'(quat_ff[3]);
   end

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         qp[i] = round_q30(prod_ff[i]);
      end
      one_q30 = MAT_W'(64'sd1073741824);
      mat_in[0][0] = one_q30 - ((MAT_W'(qp[1]) + MAT_W'(qp[2])) <<< 1);
      mat_in[0][1] = (MAT_W'(qp[3]) - MAT_W'(qp[8])) <<< 1;
      mat_in[0][2] = (MAT_W'(qp[4]) + MAT_W'(qp[7])) <<< 1;
      mat_in[1][0] = (MAT_W'(qp[3]) + MAT_W'(qp[8])) <<< 1;
      mat_in[1][1] = one_q30 - ((MAT_W'(qp[0]) + MAT_W'(qp[2])) <<< 1);
      mat_in[1][2] = (MAT_W'(qp[5]) - MAT_W'(qp[6])) <<< 1;
      mat_in[2][0] = (MAT_W'(qp[4]) - MAT_W'(qp[7])) <<< 1;
      mat_in[2][1] = (MAT_W'(qp[5]) + MAT_W'(qp[6])) <<< 1;
      mat_in[2][2] = one_q30 - ((MAT_W'(qp[0]) + MAT_W'(qp[1])) <<< 1);
   end

   always_ff @(posedge clock) begin
      mat_ff <= mat_in;
   end

endmodule

FILE: design/qpt_row.sv
// ----------------------------------------------------------------------------
// qpt_row: one output coordinate
// Four stages: split multiplies, partial sums, round to Q16.16, saturate.
// ----------------------------------------------------------------------------
module qpt_row
   import qpt_pkg::*;
(
   input  logic                      clock,
   input  stage_adv_type             adv,
   input  logic signed [MAT_W-1:0]   coef [3],
   input  logic signed [COORD_W-1:0] offset,
   input  logic signed [COORD_W-1:0] point [3],
   output logic signed [COORD_W-1:0] world_ff,
   output logic                      sat_ff
);

   logic signed [PROD_W-1:0] phi_in [3];
   logic signed [PROD_W-1:0] plo_in [3];
   logic signed [PROD_W-1:0] phi_ff [3];
   logic signed [PROD_W-1:0] plo_ff [3];
   logic signed [HI_W-1:0]   hi_in, hi_ff;
   logic signed [LO_W-1:0]   lo_in, lo_ff;
   logic signed [TOT_W-1:0]  total;
   logic signed [RND_W-1:0]  rnd_in, rnd_ff;
   logic signed [COORD_W-1:0] world_in;
   logic                     sat_in;

   // Split each coordinate into a signed high half and an unsigned low half
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         phi_in[i] = PROD_W'(coef[i]) * PROD_W'($signed(point[i][31:16]));
         plo_in[i] = PROD_W'(coef[i]) * PROD_W'($signed({1'b0, point[i][15:0]}));
      end
   end

   always_comb begin
      hi_in = HI_W'(phi_ff[0]) + HI_W'(phi_ff[1]) + HI_W'(phi_ff[2]);
      lo_in = LO_W'(plo_ff[0]) + LO_W'(plo_ff[1]) + LO_W'(plo_ff[2])
            + (LO_W'(offset) <<< FRAC_Q);
   end

   // Round half up: add one half of an output LSB, then floor
   always_comb begin
      total  = (TOT_W'(hi_ff) <<< 16) + TOT_W'(lo_ff)
             + (TOT_W'(1) <<< (FRAC_Q - 1));
      rnd_in = $signed(total[TOT_W-1:FRAC_Q]);
   end

   always_comb begin
      sat_in   = 1'b0;
      world_in = rnd_ff[COORD_W-1:0];
      if (rnd_ff[RND_W-1:COORD_W-1] != {(RND_W-COORD_W+1){rnd_ff[RND_W-1]}}) begin
         sat_in   = 1'b1;
         world_in = rnd_ff[RND_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                    : {1'b0, {(COORD_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         phi_ff <= phi_in;
         plo_ff <= plo_in;
      end
      if (adv.s2) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
      if (adv.s3) begin
         rnd_ff <= rnd_in;
      end
      if (adv.s4) begin
         world_ff <= world_in;
         sat_ff   <= sat_in;
      end
   end

endmodule

FILE: design/quaternion_point_transform_top.sv
// ----------------------------------------------------------------------------
// quaternion_point_transform_top: rigid-body point transform
// Rotates each point by the configured quaternion matrix, adds the offset,
// rounds to Q16.16 and saturates to 32 bits.
// ----------------------------------------------------------------------------
// The first of the four row stages loads at the edge that accepts a
// request; rsp_tvalid rises when that point reaches the last stage.
// Throughput: one point per cycle; the four-stage row pipeline takes a new
// point every clock while every stage can move on and busy is low.
// After a csr write (and after reset) req_tready stays low while the
// product and matrix registers take up the new quaternion.
// Reset (synchronous, active high) restores w = 1.0, all other registers 0,
// and empties the pipeline.
module quaternion_point_transform_top
   import qpt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [3*COORD_W-1:0] req_tdata,   // local_x, local_y, local_z
   // response stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [3*COORD_W-1:0] rsp_tdata,   // world_x, world_y, world_z
   output logic                 rsp_tuser,   // saturated
   // configuration writes
   input  logic                 csr_we,
   input  logic [IDX_W-1:0]     csr_index,
   input  logic [COORD_W-1:0]   csr_wdata
);

   logic signed [MAT_W-1:0]   mat_ff [3][3];
   logic signed [COORD_W-1:0] offset_ff [3];
   logic                      busy;
   logic signed [COORD_W-1:0] point [3];
   logic signed [COORD_W-1:0] world_ff [3];
   logic [2:0]                sat_ff;
   logic [4:1]                valid_ff;
   logic [4:1]                rdy;
   stage_adv_type             adv;

   // Coefficients: register file plus the matrix that follows from it
   qpt_coef u_coef (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .mat_ff    (mat_ff),
      .offset_ff (offset_ff),
      .busy      (busy)
   );

   // A stage may load when it is empty or its contents move on this cycle.
   // The last stage is the response register, so a stalled response still
   // leaves the earlier stages free to fill their bubbles.
   always_comb begin
      rdy[4] = !valid_ff[4] || rsp_tready;
      rdy[3] = !valid_ff[3] || rdy[4];
      rdy[2] = !valid_ff[2] || rdy[3];
      rdy[1] = !valid_ff[1] || rdy[2];
      adv.s1 = rdy[1];
      adv.s2 = rdy[2];
      adv.s3 = rdy[3];
      adv.s4 = rdy[4];
   end

   // Hold off new points while the matrix catches up with a write
   assign req_tready = rdy[1] && !busy;

   // Advance valid bits alongside the data; drop a slot only when it moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[1]) begin
            valid_ff[1] <= req_tvalid && !busy;
         end
         if (rdy[2]) begin
            valid_ff[2] <= valid_ff[1];
         end
         if (rdy[3]) begin
            valid_ff[3] <= valid_ff[2];
         end
         if (rdy[4]) begin
            valid_ff[4] <= valid_ff[3];
         end
      end
   end

   assign point[0] = req_tdata[COORD_W-1:0];
   assign point[1] = req_tdata[2*COORD_W-1:COORD_W];
   assign point[2] = req_tdata[3*COORD_W-1:2*COORD_W];

   // One pipeline per output coordinate, all sharing the same stage enables
   for (genvar r = 0; r < 3; r++) begin : g_row
      qpt_row u_row (
         .clock    (clock),
         .adv      (adv),
         .coef     (mat_ff[r]),
         .offset   (offset_ff[r]),
         .point    (point),
         .world_ff (world_ff[r]),
         .sat_ff   (sat_ff[r])
      );
   end

   assign rsp_tvalid = valid_ff[4];
   assign rsp_tdata  = {world_ff[2], world_ff[1], world_ff[0]};
   assign rsp_tuser  = |sat_ff;

endmodule

FILE: test/tb_quaternion_point_transform_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quaternion_point_transform_top: self-checking bench for the point transform
// Streams points through the block under several rotations and offsets,
// predicts every world point in the bench and compares it with each response
// transaction, while the source inserts gaps and the sink applies back-pressure.
// ----------------------------------------------------------------------------
module tb_quaternion_point_transform_top;
   import qpt_pkg::*;

   localparam int CLK_HALF    = 5;
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_STALL  = 400;   // sink hold-off, long enough to back up the pipe
   localparam int DRAIN_WAIT  = 12;    // quiet time after the last response
   localparam int MAX_REPORTS = 10;

   // Index beyond the register file; the block must drop writes to it
   localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

   localparam logic signed [31:0] S32_MAX   = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN   = 32'sh8000_0000;
   localparam logic signed [31:0] Q30_ONE   = 32'sh4000_0000;
   localparam logic signed [31:0] Q30_COS45 = 32'sd759250125;   // cos(pi/4) in Q2.30
   localparam logic signed [31:0] Q16_ONE   = 32'sh0001_0000;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_type;

   typedef struct {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic               sat;
   } world_type;

   typedef struct {
      logic signed [QUAT_W-1:0]  w;
      logic signed [QUAT_W-1:0]  x;
      logic signed [QUAT_W-1:0]  y;
      logic signed [QUAT_W-1:0]  z;
      logic signed [COORD_W-1:0] ox;
      logic signed [COORD_W-1:0] oy;
      logic signed [COORD_W-1:0] oz;
   } pose_type;

   // DUT connections; every input starts at a known value
   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [3*COORD_W-1:0] req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [3*COORD_W-1:0] rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_we     = 1'b0;
   logic [IDX_W-1:0]     csr_index  = '0;
   logic [COORD_W-1:0]   csr_wdata  = '0;

   // Bench state
   point_type points_to_send [$];    // points waiting for the driver
   world_type predicted_world [$];   // world points the block still owes us
   point_type point_on_bus;
   world_type want_world;
   pose_type  pose;                  // shadow of the register file
   int     src_idle_pct   = 0;
   int     sink_stall_pct = 0;
   int     points_sent    = 0;
   int     points_done    = 0;
   int     fault_count    = 0;
   int     cycle_count    = 0;
   int     stall_left     = 0;
   logic   stall_start    = 1'b0;

   quaternion_point_transform_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // local_x, local_y, local_z
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // world_x, world_y, world_z
      .rsp_tuser  (rsp_tuser),    // saturated
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Q2.30 x Q2.30 product rounded back to Q.30 (half rounds up, floor shift)
   function automatic logic signed [79:0] quat_product(logic signed [QUAT_W-1:0] a,
                                                       logic signed [QUAT_W-1:0] b);
      logic signed [63:0] full;
      full = 64'(a) * 64'(b);
      return (full + 64'sd536870912) >>> FRAC_Q;
   endfunction

   // Rotate by the unnormalized quaternion matrix, add the offset, round the
   // Q.46 row sum to Q16.16 and clip to 32 bits. 80 bits hold every sum exactly.
   function automatic world_type transform_point(point_type p, pose_type q);
      logic signed [79:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
      logic signed [79:0] one_q, half_q, hi_lim, lo_lim, acc;
      logic signed [79:0] m [3][3];
      logic signed [79:0] l [3];
      logic signed [79:0] off [3];
      logic [COORD_W-1:0] coord [3];
      world_type res;

      xx = quat_product(q.x, q.x);
      yy = quat_product(q.y, q.y);
      zz = quat_product(q.z, q.z);
      xy = quat_product(q.x, q.y);
      xz = quat_product(q.x, q.z);
      yz = quat_product(q.y, q.z);
      wx = quat_product(q.w, q.x);
      wy = quat_product(q.w, q.y);
      wz = quat_product(q.w, q.z);

      one_q  = 80'sd1 <<< FRAC_Q;
      half_q = 80'sd1 <<< (FRAC_Q - 1);
      hi_lim = S32_MAX;
      lo_lim = S32_MIN;

      m[0][0] = one_q - 2 * (yy + zz);
      m[0][1] = 2 * (xy - wz);
      m[0][2] = 2 * (xz + wy);
      m[1][0] = 2 * (xy + wz);
      m[1][1] = one_q - 2 * (xx + zz);
      m[1][2] = 2 * (yz - wx);
      m[2][0] = 2 * (xz - wy);
      m[2][1] = 2 * (yz + wx);
      m[2][2] = one_q - 2 * (xx + yy);

      l[0]   = p.x;
      l[1]   = p.y;
      l[2]   = p.z;
      off[0] = q.ox;
      off[1] = q.oy;
      off[2] = q.oz;

      res.sat = 1'b0;
      for (int r = 0; r < 3; r++) begin
         acc = (m[r][0] * l[0] + m[r][1] * l[1] + m[r][2] * l[2]
                + (off[r] <<< FRAC_Q) + half_q) >>> FRAC_Q;
         if (acc > hi_lim) begin
            coord[r] = S32_MAX;
            res.sat  = 1'b1;
         end else if (acc < lo_lim) begin
            coord[r] = S32_MIN;
            res.sat  = 1'b1;
         end else begin
            coord[r] = acc[COORD_W-1:0];
         end
      end
      res.x = coord[0];
      res.y = coord[1];
      res.z = coord[2];
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: offer queued points, predict each accepted transaction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         // registers only change while idle, so the shadow pose is current
         if (req_tvalid && req_tready) begin
            predicted_world.push_back(transform_point(point_on_bus, pose));
         end
         // load the next point once the current one is gone; hold it otherwise
         if (!req_tvalid || req_tready) begin
            if (points_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
               point_on_bus = points_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {point_on_bus.z, point_on_bus.y, point_on_bus.x};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Long sink hold-off, counted down on its own
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
      end else if (stall_start) begin
         stall_left <= LONG_STALL;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor: compare each accepted transaction with the oldest
   // prediction, field by field
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_world.size() == 0) begin
               if (fault_count < MAX_REPORTS) begin
                  $display("ERROR: response transaction with no point outstanding: %h %b",
                           rsp_tdata, rsp_tuser);
               end
               fault_count++;
            end else begin
               want_world = predicted_world.pop_front();
               points_done++;
               if (rsp_tdata[COORD_W-1:0]           !== want_world.x ||
                   rsp_tdata[2*COORD_W-1:COORD_W]   !== want_world.y ||
                   rsp_tdata[3*COORD_W-1:2*COORD_W] !== want_world.z ||
                   rsp_tuser                        !== want_world.sat) begin
                  if (fault_count < MAX_REPORTS) begin
                     $display("ERROR: point %0d expected x=%h y=%h z=%h sat=%b",
                              points_done, want_world.x, want_world.y, want_world.z,
                              want_world.sat);
                     $display("       got            x=%h y=%h z=%h sat=%b",
                              rsp_tdata[COORD_W-1:0], rsp_tdata[2*COORD_W-1:COORD_W],
                              rsp_tdata[3*COORD_W-1:2*COORD_W], rsp_tuser);
                  end
                  fault_count++;
               end
            end
         end
         rsp_tready <= (stall_left == 0) && ($urandom_range(99) >= sink_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ERROR: cycle limit hit, %0d points outstanding", points_sent - points_done);
         $display("FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic queue_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      point_type p;
      p.x = x;
      p.y = y;
      p.z = z;
      points_to_send.push_back(p);
      points_sent++;
   endtask

   // Hold until every queued point has come back, then let the pipe settle
   task automatic wait_all_back();
      while (points_done != points_sent) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(logic [IDX_W-1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   // Drain, then write all seven registers back to back
   task automatic load_pose(pose_type p);
      wait_all_back();
      write_csr(REG_ROT_W,    p.w);
      write_csr(REG_ROT_X,    p.x);
      write_csr(REG_ROT_Y,    p.y);
      write_csr(REG_ROT_Z,    p.z);
      write_csr(REG_OFFSET_X, p.ox);
      write_csr(REG_OFFSET_Y, p.oy);
      write_csr(REG_OFFSET_Z, p.oz);
      @(posedge clock);
      csr_we <= 1'b0;
      pose = p;
   endtask

   task automatic set_pacing(int src_pct, int sink_pct);
      src_idle_pct   = src_pct;
      sink_stall_pct = sink_pct;
   endtask

   // Mix of full-range, moderate, tiny and extreme coordinates
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0, 1: return $urandom;
         2, 3: return $urandom_range(32'h001F_FFFF) - 32'h0010_0000;
         4:    return $urandom_range(511) - 256;
         default: begin
            case ($urandom_range(3))
               0:       return S32_MAX;
               1:       return S32_MIN;
               2:       return 32'hFFFF_FFFF;
               default: return 32'h0000_0000;
            endcase
         end
      endcase
   endfunction

   // Quaternion component within +/-1.0
   function automatic logic [31:0] rand_quat_part();
      return $urandom_range(32'h7FFF_FFFF) - 32'h4000_0000;
   endfunction

   function automatic pose_type rand_pose(bit wide);
      pose_type p;
      p.w  = wide ? $urandom : rand_quat_part();
      p.x  = wide ? $urandom : rand_quat_part();
      p.y  = wide ? $urandom : rand_quat_part();
      p.z  = wide ? $urandom : rand_quat_part();
      p.ox = rand_coord();
      p.oy = rand_coord();
      p.oz = rand_coord();
      return p;
   endfunction

   task automatic random_points(int count);
      repeat (count) queue_point(rand_coord(), rand_coord(), rand_coord());
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      pose = '{w: Q30_ONE, x: 0, y: 0, z: 0, ox: 0, oy: 0, oz: 0};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Identity pose out of reset: every point should come back unchanged
      set_pacing(0, 0);
      queue_point(32'h0, 32'h0, 32'h0);
      queue_point(S32_MAX, S32_MAX, S32_MAX);
      queue_point(S32_MIN, S32_MIN, S32_MIN);
      queue_point(32'hFFFF_FFFF, 32'h1, Q16_ONE);
      queue_point(S32_MIN, S32_MAX, 32'h0);
      queue_point(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000);

      // Quarter turn about z with a small offset; push coordinates past the
      // 32-bit range on each axis, upward on x and y and downward on z
      load_pose('{w: Q30_COS45, x: 0, y: 0, z: Q30_COS45,
                  ox: 32'sh0001_8000, oy: 32'sh0002_4000, oz: -32'sh0000_8000});
      // stray write past the register file: must leave the pose untouched
      write_csr(REG_UNUSED, 32'hDEAD_BEEF);
      @(posedge clock);
      csr_we <= 1'b0;
      queue_point(Q16_ONE, 32'h0, 32'h0);
      queue_point(32'h0, Q16_ONE, 32'h0);
      queue_point(S32_MAX, 32'h0, 32'h0);
      queue_point(32'h0, S32_MIN, 32'h0);
      queue_point(32'h0, 32'h0, S32_MIN);
      queue_point(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
      random_points(100);

      // Random unit-ish pose, bursty source
      load_pose(rand_pose(1'b0));
      set_pacing(60, 0);
      random_points(150);

      // Every register at its most negative value: heavy shear and clipping
      load_pose('{w: S32_MIN, x: S32_MIN, y: S32_MIN, z: S32_MIN,
                  ox: S32_MIN, oy: S32_MIN, oz: S32_MIN});
      set_pacing(0, 60);
      queue_point(32'h1, 32'h1, 32'h1);
      queue_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      random_points(100);

      // Every register at its most positive value
      load_pose('{w: S32_MAX, x: S32_MAX, y: S32_MAX, z: S32_MAX,
                  ox: S32_MAX, oy: S32_MAX, oz: S32_MAX});
      set_pacing(15, 15);
      queue_point(32'h0, 32'h0, 32'h0);
      queue_point(S32_MIN, S32_MIN, S32_MIN);
      random_points(100);

      // Half turn about x; hold the sink off for a long stretch while the
      // source keeps offering, so the pipe fills and req_tready drops
      load_pose('{w: 0, x: Q30_ONE, y: 0, z: 0,
                  ox: S32_MIN, oy: S32_MAX, oz: 32'sh0000_0001});
      set_pacing(0, 0);
      stall_start <= 1'b1;
      @(posedge clock);
      stall_start <= 1'b0;
      random_points(150);

      // Random unit-ish pose again, source gaps
      load_pose(rand_pose(1'b0));
      set_pacing(60, 0);
      random_points(150);

      // Full-range unnormalized pose, sink stalls
      load_pose(rand_pose(1'b1));
      set_pacing(0, 60);
      random_points(100);

      wait_all_back();
      if (fault_count == 0 && predicted_world.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
